>>> design/ctm_pkg.sv
// Shared constants and elaboration helpers for the carry-save tree multiplier.
`default_nettype none

package ctm_pkg;

   // Operand width used by the tree, and the fixed port field widths
   localparam int WIDTH  = 16;
   localparam int IN_W   = 16;
   localparam int OUT_W  = 32;
   localparam int VEC_W  = 2 * WIDTH;
   localparam int ROW_MAX = WIDTH;

   // Widths large enough to hold both the port field and the internal value
   localparam int OPX_W  = (WIDTH > IN_W) ? WIDTH : IN_W;
   localparam int PRODX_W = (VEC_W > OUT_W) ? VEC_W : OUT_W;

   // Rows left after one level of 3:2 reduction
   function automatic int ctm_next_rows(input int cnt);
      int c;
      int g;
      c = cnt;
      g = 0;
      while (c >= 3) begin
         c = c - 3;
         g = g + 1;
      end
      return 2 * g + c;
   endfunction

   // Row count entering a given tree level
   function automatic int ctm_rows_at(input int lvl);
      int c;
      c = WIDTH;
      for (int i = 0; i < lvl; i++) begin
         c = ctm_next_rows(c);
      end
      return c;
   endfunction

   // Number of reduction levels until two rows remain
   function automatic int ctm_levels();
      int c;
      int n;
      c = WIDTH;
      n = 0;
      while (c > 2) begin
         c = ctm_next_rows(c);
         n = n + 1;
      end
      return n;
   endfunction

   localparam int LEVELS = ctm_levels();

endpackage

`default_nettype wire

>>> design/ctm_tree.sv
// Combinational carry-save reduction tree with final carry-propagate adder.
`default_nettype none

module ctm_tree import ctm_pkg::*; (
   input  wire logic [WIDTH-1:0] op_a,
   input  wire logic [WIDTH-1:0] op_b,
   output logic      [VEC_W-1:0] product
);

   logic [VEC_W-1:0] lvl_rows [LEVELS+1][ROW_MAX];

   // Form the partial-product rows, one per multiplier bit
   for (genvar r = 0; r < ROW_MAX; r++) begin : g_pp
      assign lvl_rows[0][r] = op_b[r] ? (VEC_W'(op_a) << r) : '0;
   end

   // Reduce each level: full-adder rows over groups of three, pass the rest
   for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
      localparam int CNT  = ctm_rows_at(l);
      localparam int NXT  = ctm_next_rows(CNT);
      localparam int GRP  = (CNT - (NXT - CNT / 3 * 2 - CNT % 3 + CNT % 3)) / 3;
      for (genvar r = 0; r < ROW_MAX; r++) begin : g_row
         if (r < 2 * GRP) begin : g_csa
            localparam int K = 3 * (r / 2);
            if (r % 2 == 0) begin : g_sum
               assign lvl_rows[l+1][r] =
                  lvl_rows[l][K] ^ lvl_rows[l][K+1] ^ lvl_rows[l][K+2];
            end else begin : g_carry
               assign lvl_rows[l+1][r] =
                  ((lvl_rows[l][K] & lvl_rows[l][K+1]) |
                   (lvl_rows[l][K+1] & lvl_rows[l][K+2]) |
                   (lvl_rows[l][K] & lvl_rows[l][K+2])) << 1;
            end
         end else if (r < NXT) begin : g_pass
            assign lvl_rows[l+1][r] = lvl_rows[l][r + GRP];
         end else begin : g_zero
            assign lvl_rows[l+1][r] = '0;
         end
      end
   end

   // Add the last two rows
   assign product = lvl_rows[LEVELS][0] + lvl_rows[LEVELS][1];

endmodule

`default_nettype wire

>>> design/csa_tree_multiplier.sv
// Top level: operand register, carry-save tree, product register.
// The product strobes on rsp_valid after the start beat passes the operand and product registers.
// Throughput: one operand pair per cycle; busy stays low, as the single
// registered tree pass between the operand and product registers sets the rate.
// Reset (synchronous, active high) clears both valid flags; data is not reset.
// The receiver cannot stall: each product is shown for exactly one cycle.
`default_nettype none

module csa_tree_multiplier import ctm_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [IN_W-1:0]   req_multiplicand,
   input  wire logic [IN_W-1:0]   req_multiplier,
   output logic                   rsp_valid,
   output logic      [OUT_W-1:0]  rsp_product
);

   logic             op_valid_ff;
   logic             op_valid_in;
   logic [WIDTH-1:0] op_a_ff;
   logic [WIDTH-1:0] op_a_in;
   logic [WIDTH-1:0] op_b_ff;
   logic [WIDTH-1:0] op_b_in;
   logic             rsp_valid_ff;
   logic [OUT_W-1:0] product_ff;
   logic [OUT_W-1:0] product_in;

   logic [OPX_W-1:0]   ext_a;
   logic [OPX_W-1:0]   ext_b;
   logic [VEC_W-1:0]   tree_product;
   logic [PRODX_W-1:0] ext_product;

   // Never hold off a beat
   assign busy = 1'b0;

   // Take the low operand bits, zero above the field
   assign ext_a   = OPX_W'(req_multiplicand);
   assign ext_b   = OPX_W'(req_multiplier);
   assign op_a_in = ext_a[WIDTH-1:0];
   assign op_b_in = ext_b[WIDTH-1:0];
   assign op_valid_in = start & ~busy;

   ctm_tree u_tree (
      .op_a    (op_a_ff),
      .op_b    (op_b_ff),
      .product (tree_product)
   );

   // Fit the product to the result field
   assign ext_product = PRODX_W'(tree_product);
   assign product_in  = ext_product[OUT_W-1:0];

   // Advance the valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         op_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         op_valid_ff  <= op_valid_in;
         rsp_valid_ff <= op_valid_ff;
      end
   end

   // Capture operands and product
   always_ff @(posedge clock) begin
      if (op_valid_in) begin
         op_a_ff <= op_a_in;
         op_b_ff <= op_b_in;
      end
      if (op_valid_ff) begin
         product_ff <= product_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_product = product_ff;

endmodule

`default_nettype wire
